### design/pit_pkg.sv
// Shared constants for the point-in-triangle coverage test.
// Used by pit_weight and the top level; depends on nothing.
`timescale 1ns / 1ps

package pit_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int COORD_BITS_MIN = 8;
    localparam int COORD_BITS_MAX = 24;

    // Configuration register file.
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam logic [CFG_IDX_BITS-1:0] REG_WEIGHT_TOL = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEGEN_LIMIT = 2'd1;

    localparam logic [CFG_DATA_BITS-1:0] WEIGHT_TOL_RESET = 16'd655;
    localparam logic [CFG_DATA_BITS-1:0] DEGEN_LIMIT_RESET = 16'd1;

    // Weights are compared in Q0.16, so one is a shift by this many bits.
    localparam int FRAC_BITS = 16;

    // Number of register stages from the input up to and including the result register.
    localparam int STAGES = 6;

endpackage

### design/pit_diff.sv
// First stage: coordinate differences relative to the third vertex.
// Depends on pit_pkg only through the parameter defaults of the top level.
`timescale 1ns / 1ps

module pit_diff #(
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic signed [COORD_BITS-1:0] first_x,
    input  logic signed [COORD_BITS-1:0] first_y,
    input  logic signed [COORD_BITS-1:0] second_x,
    input  logic signed [COORD_BITS-1:0] second_y,
    input  logic signed [COORD_BITS-1:0] third_x,
    input  logic signed [COORD_BITS-1:0] third_y,
    output logic signed [COORD_BITS:0]   d12y,
    output logic signed [COORD_BITS:0]   d21x,
    output logic signed [COORD_BITS:0]   d02x,
    output logic signed [COORD_BITS:0]   d02y,
    output logic signed [COORD_BITS:0]   d20y,
    output logic signed [COORD_BITS:0]   dpx,
    output logic signed [COORD_BITS:0]   dpy
);

    localparam int DW = COORD_BITS + 1;

    logic signed [DW-1:0] d12y_reg, d21x_reg, d02x_reg, d02y_reg, d20y_reg, dpx_reg, dpy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d12y_reg <= DW'(second_y) - DW'(third_y);
            d21x_reg <= DW'(third_x) - DW'(second_x);
            d02x_reg <= DW'(first_x) - DW'(third_x);
            d02y_reg <= DW'(first_y) - DW'(third_y);
            d20y_reg <= DW'(third_y) - DW'(first_y);
            dpx_reg  <= DW'(point_x) - DW'(third_x);
            dpy_reg  <= DW'(point_y) - DW'(third_y);
        end
    end

    assign d12y = d12y_reg;
    assign d21x = d21x_reg;
    assign d02x = d02x_reg;
    assign d02y = d02y_reg;
    assign d20y = d20y_reg;
    assign dpx  = dpx_reg;
    assign dpy  = dpy_reg;

endmodule

### design/pit_cross.sv
// Second and third stages: six partial products, then the doubled area and
// the two barycentric numerators. Depends on pit_diff outputs.
`timescale 1ns / 1ps

module pit_cross #(
    parameter int COORD_BITS = 16
) (
    input  logic                           clk,
    input  logic [1:0]                     en,
    input  logic signed [COORD_BITS:0]     d12y,
    input  logic signed [COORD_BITS:0]     d21x,
    input  logic signed [COORD_BITS:0]     d02x,
    input  logic signed [COORD_BITS:0]     d02y,
    input  logic signed [COORD_BITS:0]     d20y,
    input  logic signed [COORD_BITS:0]     dpx,
    input  logic signed [COORD_BITS:0]     dpy,
    output logic signed [2*COORD_BITS+2:0] den,
    output logic signed [2*COORD_BITS+2:0] na,
    output logic signed [2*COORD_BITS+2:0] nb
);

    localparam int PW = 2 * COORD_BITS + 2;
    localparam int SW = 2 * COORD_BITS + 3;

    logic signed [PW-1:0] pd0_reg, pd1_reg, pa0_reg, pa1_reg, pb0_reg, pb1_reg;
    logic signed [SW-1:0] den_reg, na_reg, nb_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pd0_reg <= PW'(d12y) * PW'(d02x);
            pd1_reg <= PW'(d21x) * PW'(d02y);
            pa0_reg <= PW'(d12y) * PW'(dpx);
            pa1_reg <= PW'(d21x) * PW'(dpy);
            pb0_reg <= PW'(d20y) * PW'(dpx);
            pb1_reg <= PW'(d02x) * PW'(dpy);
        end
        if (en[1])
        begin
            den_reg <= SW'(pd0_reg) + SW'(pd1_reg);
            na_reg  <= SW'(pa0_reg) + SW'(pa1_reg);
            nb_reg  <= SW'(pb0_reg) + SW'(pb1_reg);
        end
    end

    assign den = den_reg;
    assign na  = na_reg;
    assign nb  = nb_reg;

endmodule

### design/pit_norm.sv
// Fourth stage: flips all signs if the area is negative, so that it is not, and forms the
// third numerator. Depends on pit_cross outputs.
`timescale 1ns / 1ps

module pit_norm #(
    parameter int COORD_BITS = 16
) (
    input  logic                           clk,
    input  logic                           en,
    input  logic signed [2*COORD_BITS+2:0] den,
    input  logic signed [2*COORD_BITS+2:0] na,
    input  logic signed [2*COORD_BITS+2:0] nb,
    output logic [2*COORD_BITS+2:0]        mag,
    output logic signed [2*COORD_BITS+4:0] wa,
    output logic signed [2*COORD_BITS+4:0] wb,
    output logic signed [2*COORD_BITS+4:0] wc
);

    localparam int SW = 2 * COORD_BITS + 3;
    localparam int NW = 2 * COORD_BITS + 5;

    logic signed [NW-1:0] den_x, na_x, nb_x;
    logic [SW-1:0]        mag_reg;
    logic signed [NW-1:0] wa_reg, wb_reg, wc_reg;

    always_comb
    begin
        if (den[SW-1])
        begin
            den_x = -NW'(den);
            na_x  = -NW'(na);
            nb_x  = -NW'(nb);
        end
        else
        begin
            den_x = NW'(den);
            na_x  = NW'(na);
            nb_x  = NW'(nb);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= den_x[SW-1:0];
            wa_reg  <= na_x;
            wb_reg  <= nb_x;
            wc_reg  <= den_x - na_x - nb_x;
        end
    end

    assign mag = mag_reg;
    assign wa  = wa_reg;
    assign wb  = wb_reg;
    assign wc  = wc_reg;

endmodule

### design/pit_weight.sv
// Fifth and sixth stages: degenerate check, area times tolerance in two
// partial products, then the three weight compares. Depends on pit_pkg.
`timescale 1ns / 1ps

module pit_weight #(
    parameter int COORD_BITS = 16
) (
    input  logic                                clk,
    input  logic [1:0]                          en,
    input  logic [pit_pkg::CFG_DATA_BITS-1:0]   weight_tol,
    input  logic [pit_pkg::CFG_DATA_BITS-1:0]   degen_limit,
    input  logic [2*COORD_BITS+2:0]             mag,
    input  logic signed [2*COORD_BITS+4:0]      wa,
    input  logic signed [2*COORD_BITS+4:0]      wb,
    input  logic signed [2*COORD_BITS+4:0]      wc,
    output logic                                inside_res,
    output logic                                degenerate
);

    localparam int TB = pit_pkg::CFG_DATA_BITS;
    localparam int MB = 2 * COORD_BITS + 3;
    localparam int NW = 2 * COORD_BITS + 5;
    localparam int LO = MB / 2;
    localparam int HI = MB - LO;
    localparam int CW = NW + pit_pkg::FRAC_BITS;

    logic [LO+TB-1:0] p_lo_reg;
    logic [HI+TB-1:0] p_hi_reg;
    logic [NW-1:0]    abs_reg [3];
    logic [2:0]       neg_reg;
    logic             degen_reg;
    logic             inside_out_reg, degen_out_reg;

    logic signed [NW-1:0] w_in [3];
    logic [CW-1:0]        prod;
    logic [2:0]           ok;
    logic                 degen_now;

    assign w_in[0] = wa;
    assign w_in[1] = wb;
    assign w_in[2] = wc;

    // A zero area is degenerate even with a zero limit.
    assign degen_now = (mag == '0) || (mag < MB'(degen_limit));

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p_lo_reg  <= (LO+TB)'(mag[LO-1:0]) * (LO+TB)'(weight_tol);
            p_hi_reg  <= (HI+TB)'(mag[MB-1:LO]) * (HI+TB)'(weight_tol);
            degen_reg <= degen_now;
            for (int i = 0; i < 3; i++)
            begin
                neg_reg[i] <= w_in[i][NW-1];
                abs_reg[i] <= w_in[i][NW-1] ? NW'(-w_in[i]) : NW'(w_in[i]);
            end
        end
    end

    assign prod = (CW'(p_hi_reg) << LO) + CW'(p_lo_reg);

    // A negative weight passes when |n| * 2^16 <= area * tolerance.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ok[i] = !neg_reg[i] || ({abs_reg[i], {pit_pkg::FRAC_BITS{1'b0}}} <= prod);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            inside_out_reg <= !degen_reg && (&ok);
            degen_out_reg  <= degen_reg;
        end
    end

    assign inside_res = inside_out_reg;
    assign degenerate = degen_out_reg;

endmodule

### design/point_in_triangle_test.sv
// Top level of the point-in-triangle coverage test: configuration registers,
// stage valid chain and flow control. Depends on pit_pkg and all pit_ modules.
`timescale 1ns / 1ps

// Takes one item per clock unless a stalled output backs up to the input, and
// returns one result per item, in order. The six register stages are
// differences, products, sums, sign fix, area-times-tolerance partial
// products, and the final compare into the output register. Each stage
// moves on when it is empty or the stage after it moves, so bubbles are
// squeezed out and a stalled output holds only as much as it must.
// Write configuration only while no item is in flight.
module point_in_triangle_test #(
    parameter int COORD_BITS = pit_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [COORD_BITS-1:0]        point_x,
    input  logic signed [COORD_BITS-1:0]        point_y,
    input  logic signed [COORD_BITS-1:0]        first_x,
    input  logic signed [COORD_BITS-1:0]        first_y,
    input  logic signed [COORD_BITS-1:0]        second_x,
    input  logic signed [COORD_BITS-1:0]        second_y,
    input  logic signed [COORD_BITS-1:0]        third_x,
    input  logic signed [COORD_BITS-1:0]        third_y,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                inside_res,
    output logic                                degenerate,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pit_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [pit_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int NS = pit_pkg::STAGES;

    logic [pit_pkg::CFG_DATA_BITS-1:0] weight_tol_reg, degen_limit_reg;
    logic [NS-1:0] valid_reg, valid_next;
    logic [NS-1:0] en;

    logic signed [COORD_BITS:0]     d12y, d21x, d02x, d02y, d20y, dpx, dpy;
    logic signed [2*COORD_BITS+2:0] den, na, nb;
    logic [2*COORD_BITS+2:0]        mag;
    logic signed [2*COORD_BITS+4:0] wa, wb, wc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_tol_reg  <= pit_pkg::WEIGHT_TOL_RESET;
            degen_limit_reg <= pit_pkg::DEGEN_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == pit_pkg::REG_WEIGHT_TOL)
                weight_tol_reg <= cfg_data;
            else if (cfg_index == pit_pkg::REG_DEGEN_LIMIT)
                degen_limit_reg <= cfg_data;
        end
    end

    // A stage loads when it is empty or its contents move on downstream.
    always_comb
    begin
        en[NS-1] = !valid_reg[NS-1] || !out_stall;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
        valid_next[0] = en[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < NS; i++)
        begin
            valid_next[i] = en[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign in_stall  = !en[0];
    assign out_valid = valid_reg[NS-1];

    pit_diff #(.COORD_BITS(COORD_BITS)) u_diff (
        .clk      (clk),
        .en       (en[0]),
        .point_x  (point_x),
        .point_y  (point_y),
        .first_x  (first_x),
        .first_y  (first_y),
        .second_x (second_x),
        .second_y (second_y),
        .third_x  (third_x),
        .third_y  (third_y),
        .d12y     (d12y),
        .d21x     (d21x),
        .d02x     (d02x),
        .d02y     (d02y),
        .d20y     (d20y),
        .dpx      (dpx),
        .dpy      (dpy)
    );

    pit_cross #(.COORD_BITS(COORD_BITS)) u_cross (
        .clk  (clk),
        .en   (en[2:1]),
        .d12y (d12y),
        .d21x (d21x),
        .d02x (d02x),
        .d02y (d02y),
        .d20y (d20y),
        .dpx  (dpx),
        .dpy  (dpy),
        .den  (den),
        .na   (na),
        .nb   (nb)
    );

    pit_norm #(.COORD_BITS(COORD_BITS)) u_norm (
        .clk (clk),
        .en  (en[3]),
        .den (den),
        .na  (na),
        .nb  (nb),
        .mag (mag),
        .wa  (wa),
        .wb  (wb),
        .wc  (wc)
    );

    pit_weight #(.COORD_BITS(COORD_BITS)) u_weight (
        .clk         (clk),
        .en          (en[5:4]),
        .weight_tol  (weight_tol_reg),
        .degen_limit (degen_limit_reg),
        .mag         (mag),
        .wa          (wa),
        .wb          (wb),
        .wc          (wc),
        .inside_res  (inside_res),
        .degenerate  (degenerate)
    );

    // A degenerate triangle never reports the point inside.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(inside_res && degenerate))
    else $error("degenerate result reported inside");

    // The input may only stall when a result is held at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the output is free");

    // An item accepted into an empty first stage shows up there next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> valid_reg[0])
    else $error("accepted item lost in the first stage");

endmodule
